@@ design/lzss_window_decoder_assert.svh @@
// Assertion macros for the LZSS window decoder.
`ifndef LZSS_WINDOW_DECODER_ASSERT_SVH
`define LZSS_WINDOW_DECODER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define LZWD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define LZWD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LZWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lzwd_pkg.sv @@
// Types and constants shared by the LZSS window decoder modules.
package lzwd_pkg;

    localparam int WIN_SIZE       = 1024;
    localparam int WIN_AW         = $clog2(WIN_SIZE);
    localparam int PRESET_DEFAULT = 960;
    localparam int QDEPTH         = 4;
    localparam int Q_AW           = $clog2(QDEPTH);

    localparam logic [7:0] FILL_BYTE = 8'h20;

    typedef logic [WIN_AW-1:0] t_waddr;
    typedef logic [WIN_AW:0]   t_fill;
    typedef logic [Q_AW-1:0]   t_qptr;
    typedef logic [Q_AW:0]     t_qcnt;

    typedef enum logic [2:0] {
        PH_HDR_HI,
        PH_HDR_LO,
        PH_CMD,
        PH_LIT,
        PH_WHI,
        PH_WLO,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic       clear;
        logic       wr_en;
        logic [7:0] wr_data;
        logic       rd_en;
        t_waddr     rd_addr;
    } t_win_req;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } t_out_item;

endpackage

@@ design/lzwd_window.sv @@
// History window RAM with fill-count preset and write-to-read forwarding.
module lzwd_window #(
    parameter int PRESET_LENGTH = lzwd_pkg::PRESET_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzwd_pkg::t_win_req i_req,
    output logic [7:0]         o_rd_data
);

    localparam lzwd_pkg::t_waddr BASE =
        lzwd_pkg::t_waddr'(PRESET_LENGTH % lzwd_pkg::WIN_SIZE);
    localparam lzwd_pkg::t_fill FILL_FULL = lzwd_pkg::t_fill'(lzwd_pkg::WIN_SIZE);

    logic [7:0]       r_mem [lzwd_pkg::WIN_SIZE];
    lzwd_pkg::t_waddr r_wp, n_wp;
    lzwd_pkg::t_fill  r_fill, n_fill;
    lzwd_pkg::t_waddr rd_off;
    logic             rd_written;
    logic             wr_go;
    logic [7:0]       r_q;
    logic [7:0]       r_fwd;
    logic             r_hit;
    logic             r_valid;

    // entries written since preset form one run starting at BASE
    assign rd_off     = i_req.rd_addr - BASE;
    assign rd_written = {1'b0, rd_off} < r_fill;
    assign wr_go      = i_req.wr_en && !i_req.clear;

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (i_req.clear) begin
            n_wp   = BASE;
            n_fill = '0;
        end else if (i_req.wr_en) begin
            n_wp = r_wp + 1'b1;
            if (r_fill != FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= BASE;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
        r_fwd   <= i_req.wr_data;
        r_hit   <= i_req.rd_en && wr_go && (i_req.rd_addr == r_wp);
        r_valid <= rd_written;
    end

    assign o_rd_data = r_hit ? r_fwd : (r_valid ? r_q : lzwd_pkg::FILL_BYTE);

endmodule

@@ design/lzwd_out_queue.sv @@
// Small output queue that holds decoded items until the sink takes them.
module lzwd_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lzwd_pkg::t_out_item i_item,
    input  logic                i_stall,
    output logic                o_valid,
    output lzwd_pkg::t_out_item o_item,
    output lzwd_pkg::t_qcnt     o_count
);

    lzwd_pkg::t_out_item r_buf [lzwd_pkg::QDEPTH];
    lzwd_pkg::t_qptr     r_rd, r_wr;
    lzwd_pkg::t_qcnt     r_cnt, n_cnt;
    logic                pop;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_buf[r_rd];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

endmodule

@@ design/lzss_window_decoder.sv @@
// LZSS decoder top level: stream parser, back-reference copy engine, window and output queue.
// Header, flag and literal bytes are taken one per cycle while the output queue
// has room. A back-reference word holds the input until its copy is done:
// the copy reads one byte per cycle from the 1024-byte window RAM, whose read
// data is registered; a stalled sink slows it once the four-item output queue
// fills. The window preset to 0x20 is tracked by a fill count, so there is no
// clearing pass after reset or stream start.
// Overlapping copies read bytes written by the same copy through forwarding.
`include "lzss_window_decoder_assert.svh"

module lzss_window_decoder #(
    parameter int PRESET_LENGTH = lzwd_pkg::PRESET_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_end
);

    lzwd_pkg::t_phase    r_phase, n_phase;
    logic [15:0]         r_rem, n_rem;
    logic [7:0]          r_flags, n_flags;
    logic [3:0]          r_left, n_left;
    logic [7:0]          r_hi, n_hi;

    lzwd_pkg::t_phase    e_phase;
    logic [15:0]         e_rem;
    logic [7:0]          e_flags;
    logic [3:0]          e_left;
    logic [7:0]          e_hi;
    lzwd_pkg::t_phase    act;
    logic [15:0]         rem_dec;
    logic                in_acc;
    logic                lit_push;
    logic                copy_go;

    logic [6:0]          r_copy_left;
    lzwd_pkg::t_waddr    r_src;
    logic                r_copy_end;
    logic                r_pend;
    logic                r_pend_last;
    logic                r_pend_end;
    logic                issue;

    lzwd_pkg::t_win_req  win_req;
    logic [7:0]          win_rd;
    lzwd_pkg::t_out_item q_item;
    lzwd_pkg::t_out_item q_head;
    lzwd_pkg::t_qcnt     q_cnt;
    logic                q_push;

    function automatic logic [15:0] sat_dec(input logic [15:0] v);
        return (v == 16'd0) ? 16'd0 : v - 16'd1;
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_copy_left != 7'd0) || r_pend ||
                        (q_cnt == lzwd_pkg::t_qcnt'(lzwd_pkg::QDEPTH));

    // stream start re-initializes the parser before this byte is parsed
    assign e_phase = i_stream_start ? lzwd_pkg::PH_HDR_HI : r_phase;
    assign e_rem   = i_stream_start ? 16'd0 : r_rem;
    assign e_flags = i_stream_start ? 8'd0 : r_flags;
    assign e_left  = i_stream_start ? 4'd0 : r_left;
    assign e_hi    = i_stream_start ? 8'd0 : r_hi;
    assign rem_dec = sat_dec(e_rem);

    always_comb begin
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_flags  = r_flags;
        n_left   = r_left;
        n_hi     = r_hi;
        act      = lzwd_pkg::PH_DONE;
        lit_push = 1'b0;
        copy_go  = 1'b0;
        if (in_acc) begin
            n_phase = e_phase;
            n_rem   = e_rem;
            n_flags = e_flags;
            n_left  = e_left;
            n_hi    = e_hi;
            case (e_phase)
                lzwd_pkg::PH_HDR_HI: begin
                    n_hi    = i_in_byte;
                    n_phase = lzwd_pkg::PH_HDR_LO;
                end
                lzwd_pkg::PH_HDR_LO: begin
                    n_rem   = {e_hi, i_in_byte};
                    n_flags = 8'd0;
                    n_left  = 4'd0;
                    n_phase = ({e_hi, i_in_byte} != 16'd0) ? lzwd_pkg::PH_CMD
                                                          : lzwd_pkg::PH_DONE;
                end
                lzwd_pkg::PH_CMD: begin
                    if (e_left == 4'd0) begin
                        n_flags = {1'b0, i_in_byte[7:1]};
                        n_left  = 4'd7;
                        n_rem   = rem_dec;
                        n_phase = i_in_byte[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_WHI;
                    end else begin
                        act     = e_flags[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_WHI;
                        n_flags = {1'b0, e_flags[7:1]};
                        n_left  = e_left - 4'd1;
                    end
                end
                lzwd_pkg::PH_LIT, lzwd_pkg::PH_WHI, lzwd_pkg::PH_WLO: begin
                    act = e_phase;
                end
                default: begin
                end
            endcase
            case (act)
                lzwd_pkg::PH_LIT: begin
                    n_rem    = rem_dec;
                    lit_push = 1'b1;
                    n_phase  = (rem_dec == 16'd0) ? lzwd_pkg::PH_DONE : lzwd_pkg::PH_CMD;
                end
                lzwd_pkg::PH_WHI: begin
                    n_hi    = i_in_byte;
                    n_rem   = rem_dec;
                    n_phase = lzwd_pkg::PH_WLO;
                end
                lzwd_pkg::PH_WLO: begin
                    n_rem   = rem_dec;
                    copy_go = 1'b1;
                    n_phase = (rem_dec == 16'd0) ? lzwd_pkg::PH_DONE : lzwd_pkg::PH_CMD;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lzwd_pkg::PH_HDR_HI;
            r_rem   <= 16'd0;
            r_flags <= 8'd0;
            r_left  <= 4'd0;
            r_hi    <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_flags <= n_flags;
            r_left  <= n_left;
            r_hi    <= n_hi;
        end
    end

    // copy engine: one window read per cycle, bounded by queue room
    assign issue = (r_copy_left != 7'd0) &&
                   ((q_cnt + lzwd_pkg::t_qcnt'(r_pend)) <
                    lzwd_pkg::t_qcnt'(lzwd_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy_left <= 7'd0;
            r_pend      <= 1'b0;
        end else begin
            r_pend <= issue;
            if (copy_go) begin
                r_copy_left <= {1'b0, e_hi[7:2]} + 7'd1;
            end else if (issue) begin
                r_copy_left <= r_copy_left - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (copy_go) begin
            r_src      <= {e_hi[1:0], i_in_byte};
            r_copy_end <= rem_dec == 16'd0;
        end else if (issue) begin
            r_src <= r_src + 1'b1;
        end
        if (issue) begin
            r_pend_last <= r_copy_left == 7'd1;
            r_pend_end  <= r_copy_end;
        end
    end

    always_comb begin
        win_req.clear   = in_acc && i_stream_start;
        win_req.wr_en   = lit_push || r_pend;
        win_req.wr_data = r_pend ? win_rd : i_in_byte;
        win_req.rd_en   = issue;
        win_req.rd_addr = r_src;
    end

    lzwd_window #(
        .PRESET_LENGTH(PRESET_LENGTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (win_req),
        .o_rd_data(win_rd)
    );

    assign q_push = lit_push || r_pend;

    always_comb begin
        if (r_pend) begin
            q_item.data       = win_rd;
            q_item.run_last   = r_pend_last;
            q_item.stream_end = r_pend_last && r_pend_end;
        end else begin
            q_item.data       = i_in_byte;
            q_item.run_last   = 1'b1;
            q_item.stream_end = rem_dec == 16'd0;
        end
    end

    lzwd_out_queue u_out_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (q_item),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_item (q_head),
        .o_count(q_cnt)
    );

    assign o_out_byte   = q_head.data;
    assign o_run_last   = q_head.run_last;
    assign o_stream_end = q_head.stream_end;

    `LZWD_ASSERT_ALWAYS(a_queue_room, i_clk, i_rst_n, (q_cnt + lzwd_pkg::t_qcnt'(r_pend)) <= lzwd_pkg::t_qcnt'(lzwd_pkg::QDEPTH), "output queue overcommitted")
    `LZWD_ASSERT_NEXT(a_copy_starts, i_clk, i_rst_n, copy_go, r_copy_left != 7'd0, "copy did not start")
    `LZWD_ASSERT_IMPL(a_last_read, i_clk, i_rst_n, r_pend && r_pend_last, r_copy_left == 7'd0, "reads issued past end of copy")
    `LZWD_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_stream_end, o_run_last, "stream end on an item that is not last of its run")

endmodule

@@ test/lzss_window_decoder_test.sv @@
// Self-checking testbench for lzss_window_decoder: directed and random streams.
module lzss_window_decoder_test;
    import lzwd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 320;
    localparam int DRAIN_CYCLES = 100;

    class lzss_scoreboard;
        logic [7:0] window [WIN_SIZE];
        t_waddr     wr_ptr;
        t_phase     phase;
        logic [15:0] body_left;
        logic [7:0] flags;
        logic [3:0] flags_left;
        logic [7:0] word_hi;
        t_out_item  expected_bytes [$];
        int         errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (window[i]) window[i] = FILL_BYTE;
            wr_ptr     = t_waddr'(PRESET_DEFAULT);
            phase      = PH_HDR_HI;
            body_left  = '0;
            flags      = '0;
            flags_left = '0;
            word_hi    = '0;
        endfunction

        function void take_body();
            if (body_left != 0) body_left--;
        endfunction

        function t_phase next_command();
            logic bit0;
            bit0  = flags[0];
            flags = flags >> 1;
            if (flags_left != 0) flags_left--;
            return bit0 ? PH_LIT : PH_WHI;
        endfunction

        function void emit_byte(logic [7:0] b);
            t_out_item o;
            o.data       = b;
            o.run_last   = 1'b0;
            o.stream_end = 1'b0;
            expected_bytes.push_back(o);
            window[wr_ptr] = b;
            wr_ptr++;
        endfunction

        function void take_byte(logic [7:0] b, logic s);
            int        reps;
            t_waddr    src;
            logic [7:0] c;
            t_out_item last;
            if (s) restart();
            case (phase)
                PH_HDR_HI: begin
                    word_hi = b;
                    phase   = PH_HDR_LO;
                    return;
                end
                PH_HDR_LO: begin
                    body_left  = {word_hi, b};
                    flags      = '0;
                    flags_left = '0;
                    phase      = (body_left != 0) ? PH_CMD : PH_DONE;
                    return;
                end
                PH_CMD: begin
                    if (flags_left == 0) begin
                        flags      = b;
                        flags_left = 4'd8;
                        take_body();
                        phase = next_command();
                        return;
                    end
                    phase = next_command();
                end
                PH_LIT, PH_WHI, PH_WLO: ;
                default: return;
            endcase

            if (phase == PH_LIT) begin
                take_body();
                emit_byte(b);
            end else if (phase == PH_WHI) begin
                word_hi = b;
                take_body();
                phase = PH_WLO;
                return;
            end else begin
                reps = int'(word_hi[7:2]) + 1;
                src  = {word_hi[1:0], b};
                take_body();
                for (int i = 0; i < reps; i++) begin
                    c = window[src];
                    src++;
                    emit_byte(c);
                end
            end

            last = expected_bytes.pop_back();
            last.run_last = 1'b1;
            if (body_left == 0) begin
                phase = PH_DONE;
                last.stream_end = 1'b1;
            end else begin
                phase = PH_CMD;
            end
            expected_bytes.push_back(last);
        endfunction

        function void check_output(logic [7:0] b, logic rl, logic se);
            t_out_item e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output item: out_byte %h", b);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (e.data !== b) begin
                $error("out_byte: expected %h, actual %h", e.data, b);
                errors++;
            end
            if (e.run_last !== rl) begin
                $error("run_last: expected %b, actual %b", e.run_last, rl);
                errors++;
            end
            if (e.stream_end !== se) begin
                $error("stream_end: expected %b, actual %b", e.stream_end, se);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_start  = 1'b0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_stream_end;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int stream_items   = 0;
    int cycles         = 0;

    lzss_scoreboard sb;

    lzss_window_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (in_byte),
        .i_stream_start (in_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_stream_end   (o_stream_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !out_stall)
                sb.check_output(o_out_byte, o_run_last, o_stream_end);
            if (in_valid && o_in_stall === 1'b0)
                sb.take_byte(in_byte, in_start);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_start <= s;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic send_random_stream();
        logic [7:0] body [$];
        logic [7:0] flag;
        logic [5:0] len;
        logic [9:0] ofs;
        logic [15:0] count;
        int cmds;
        int sent;
        cmds = $urandom_range(1, 24);
        while (cmds > 0) begin
            flag = 8'($urandom);
            body.push_back(flag);
            for (int k = 0; k < 8 && cmds > 0; k++) begin
                if (flag[k]) begin
                    body.push_back(8'($urandom));
                end else begin
                    len = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(7));
                    ofs = 10'($urandom_range(1023));
                    body.push_back({len, ofs[9:8]});
                    body.push_back(ofs[7:0]);
                end
                cmds--;
            end
        end
        count = 16'(body.size());
        case ($urandom_range(11))
            0: count = count - 16'($urandom_range(count - 1));
            1: count = count + 16'($urandom_range(1, 3));
            2: count = 16'($urandom_range(256, 65535));
            default: ;
        endcase
        // broken stream: the next start cuts it short
        sent = ($urandom_range(7) == 0) ? int'($urandom_range(body.size() - 1)) : body.size();
        send_byte(count[15:8], 1'b1);
        send_byte(count[7:0], 1'b0);
        for (int i = 0; i < sent; i++) send_byte(body[i], 1'b0);
        stream_items += sent + 2;
        repeat ($urandom_range(2)) send_byte(8'($urandom), ($urandom_range(9) == 0));
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first header without start, word running past the count, full-length copy
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b0);
        // zero count, then a trailing item
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        // literal, then a copy overlapping its own output
        send_byte(8'h00, 1'b1);
        send_byte(8'h04, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'hC0, 1'b0);
        // count covers only the flag item
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = (p == 1) ? 49 : (p == 3) ? 29 : 0;
            sink_stall_pct = (p == 2) ? 49 : (p == 3) ? 29 : 0;
            while (stream_items < (p + 1) * RANDOM_ITEMS / 4) send_random_stream();
        end
        in_valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge i_clk);

        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
